// ----- hw/rtl/hub75_pkg.sv -----
// Package with panel geometry, operation codes, payload beats and store request types.
`default_nettype none

package hub75_pkg;

    // Panel geometry
    localparam int PANEL_ROWS    = 64;
    localparam int SCAN_ROWS     = 32;
    localparam int PANEL_COLUMNS = 64;

    localparam int ROW_AW   = $clog2(PANEL_ROWS);
    localparam int SCAN_AW  = $clog2(SCAN_ROWS);
    localparam int COL_W    = $clog2(PANEL_COLUMNS);
    localparam int ENTRY_W  = 3 * PANEL_COLUMNS;
    localparam int DENTRY_W = 2 * ENTRY_W;

    // Operation codes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_CLR_PIXEL = 3'd1;
    localparam logic [2:0] OP_SET_PIXEL = 3'd2;
    localparam logic [2:0] OP_ROW_MASK  = 3'd3;
    localparam logic [2:0] OP_ROW_RAW   = 3'd4;
    localparam logic [2:0] OP_FILL      = 3'd5;
    localparam logic [2:0] OP_CLEAR     = 3'd6;

    // Raw row plane codes
    localparam logic [1:0] PLANE_RED   = 2'd0;
    localparam logic [1:0] PLANE_GREEN = 2'd1;
    localparam logic [1:0] PLANE_BLUE  = 2'd2;

    // Plane slots inside a store entry, same order as mask and rgb bits
    localparam int SLOT_BLUE  = 0;
    localparam int SLOT_GREEN = 1;
    localparam int SLOT_RED   = 2;

    localparam logic [15:0] DWELL_RESET = 16'd80;

    typedef struct packed {
        logic [2:0]  operation;
        logic [5:0]  row;
        logic [5:0]  column;
        logic [2:0]  color_mask;
        logic [1:0]  plane;
        logic [63:0] row_word;
    } t_item;

    typedef struct packed {
        logic [4:0] row_address;
        logic [2:0] upper_rgb;
        logic [2:0] lower_rgb;
        logic       shift_pulse;
        logic       latch;
        logic       display_on;
    } t_result;

    // Write store access: one write port, two read ports
    typedef struct packed {
        logic               we;
        logic [ROW_AW-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [ROW_AW-1:0]  raddr_a;
        logic [ROW_AW-1:0]  raddr_b;
    } t_ws_req;

    // Display store access: one write port, one read port
    typedef struct packed {
        logic                we;
        logic [SCAN_AW-1:0]  waddr;
        logic [DENTRY_W-1:0] wdata;
        logic [SCAN_AW-1:0]  raddr;
    } t_ds_req;

endpackage

`default_nettype wire

// ----- hw/rtl/hub75_wstore.sv -----
// Write store memory: one row of three color planes per entry, two registered read ports.
`default_nettype none

module hub75_wstore
    import hub75_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_ws_req            i_req,
    output logic [ENTRY_W-1:0]      o_rdata_a,
    output logic [ENTRY_W-1:0]      o_rdata_b
);

    logic [ENTRY_W-1:0] mem [PANEL_ROWS];
    logic [ENTRY_W-1:0] r_rdata_a;
    logic [ENTRY_W-1:0] r_rdata_b;

    // Write one row, read two rows
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata_a <= mem[i_req.raddr_a];
        r_rdata_b <= mem[i_req.raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ----- hw/rtl/hub75_dstore.sv -----
// Display store memory: one scan row (upper and lower panel rows) per entry.
`default_nettype none

module hub75_dstore
    import hub75_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_ds_req            i_req,
    output logic [DENTRY_W-1:0]     o_rdata
);

    logic [DENTRY_W-1:0] mem [SCAN_ROWS];
    logic [DENTRY_W-1:0] r_rdata;

    // Write one scan row, read one scan row
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/hub75_led_matrix_scan_driver.sv -----
// Top level: command decode, store sequencing and panel scan for the matrix driver.
//
//  channel   | ports                         | handshake
//  ----------+-------------------------------+-------------------------------------
//  command   | start, busy, i_item           | beat taken when start && !busy
//  result    | o_strobe, o_result            | beat shown for one cycle, no stall
//  config    | i_cfg_we, i_cfg_wdata         | dwell_ticks written when i_cfg_we
//
//  Scan ticks may follow back to back; the result of each appears on
//  the cycle after it is processed, when the display store read data is back.
//  The first tick of a frame first copies the write store into the display store,
//  one scan row per cycle, busy throughout; the tick runs in S_SCAN after the last write.
//  Pixel and row writes are a read-modify-write of one write store row, busy in S_RMW.
//  Fill walks all rows through the same read-modify-write, busy until the last write.
//  Reset and the clear command sweep both stores with zeros, busy during the sweep.
`default_nettype none

module hub75_led_matrix_scan_driver
    import hub75_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_item   i_item,
    input  wire logic    i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic         o_strobe,
    output t_result      o_result
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RMW   = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_COPY  = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;

    localparam int C = PANEL_COLUMNS;

    // Apply a held write command to one write store row
    function automatic logic [ENTRY_W-1:0] f_modify(
        input logic [ENTRY_W-1:0] old,
        input logic [2:0]         op,
        input logic [COL_W-1:0]   col,
        input logic [2:0]         mask,
        input logic [1:0]         plane,
        input logic [C-1:0]       word
    );
        logic [C-1:0]       bitv;
        logic [ENTRY_W-1:0] res;
        bitv      = '0;
        bitv[col] = 1'b1;
        res       = old;
        case (op)
            OP_CLR_PIXEL: begin
                for (int s = 0; s < 3; s++) begin
                    res[s*C +: C] = old[s*C +: C] & ~bitv;
                end
            end
            OP_SET_PIXEL: begin
                for (int s = 0; s < 3; s++) begin
                    if (mask[s]) res[s*C +: C] = old[s*C +: C] | bitv;
                end
            end
            OP_ROW_MASK, OP_FILL: begin
                for (int s = 0; s < 3; s++) begin
                    if (mask[s]) res[s*C +: C] = word;
                end
            end
            OP_ROW_RAW: begin
                case (plane)
                    PLANE_RED:   res[SLOT_RED*C +: C]   = word;
                    PLANE_GREEN: res[SLOT_GREEN*C +: C] = word;
                    PLANE_BLUE:  res[SLOT_BLUE*C +: C]  = word;
                    default:     res = old;
                endcase
            end
            default: res = old;
        endcase
        return res;
    endfunction

    // Sequencer state
    logic [2:0]          r_state, n_state;
    logic [ROW_AW-1:0]   r_idx, n_idx;
    logic                r_rd_on, n_rd_on;
    logic                r_wr_pend, n_wr_pend;
    logic [ROW_AW-1:0]   r_wr_idx, n_wr_idx;

    // Held write command
    logic [2:0]          r_op, n_op;
    logic [COL_W-1:0]    r_col, n_col;
    logic [2:0]          r_mask, n_mask;
    logic [1:0]          r_plane, n_plane;
    logic [C-1:0]        r_word, n_word;

    // Scan state
    logic [SCAN_AW-1:0]  r_scan_row, n_scan_row;
    logic [COL_W-1:0]    r_scan_col, n_scan_col;
    logic                r_in_dwell, n_in_dwell;
    logic [15:0]         r_dwell_count, n_dwell_count;
    logic [15:0]         r_dwell_ticks;

    // Result stage
    logic                r_out_pend, n_out_pend;
    logic [4:0]          r_out_row, n_out_row;
    logic                r_out_shift, n_out_shift;
    logic [COL_W-1:0]    r_out_col, n_out_col;

    t_ws_req             ws_req;
    t_ds_req             ds_req;
    logic [ENTRY_W-1:0]  ws_rdata_a;
    logic [ENTRY_W-1:0]  ws_rdata_b;
    logic [DENTRY_W-1:0] ds_rdata;

    logic                accept;
    logic                frame_start;
    logic                do_tick;
    logic                row_ok;
    logic                col_ok;
    logic                lower_ok;
    logic                idx_scan;
    logic [15:0]         dwell_next;
    logic [15:0]         dwell_limit;

    hub75_wstore u_wstore (
        .i_clk     (i_clk),
        .i_req     (ws_req),
        .o_rdata_a (ws_rdata_a),
        .o_rdata_b (ws_rdata_b)
    );

    hub75_dstore u_dstore (
        .i_clk   (i_clk),
        .i_req   (ds_req),
        .o_rdata (ds_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign frame_start = !r_in_dwell && (r_scan_row == '0) &&
                         (r_scan_col == COL_W'(PANEL_COLUMNS - 1));
    assign row_ok   = ({1'b0, i_item.row} < 7'(PANEL_ROWS));
    assign col_ok   = ({1'b0, i_item.column} < 7'(PANEL_COLUMNS));
    assign lower_ok = (({1'b0, r_wr_idx} + (ROW_AW+1)'(SCAN_ROWS)) <
                       (ROW_AW+1)'(PANEL_ROWS));
    assign idx_scan = ({1'b0, r_idx} < (ROW_AW+1)'(SCAN_ROWS));

    // Decode commands and sequence the store sweeps
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_rd_on   = r_rd_on;
        n_wr_pend = r_wr_pend;
        n_wr_idx  = r_wr_idx;
        n_op      = r_op;
        n_col     = r_col;
        n_mask    = r_mask;
        n_plane   = r_plane;
        n_word    = r_word;
        do_tick   = 1'b0;

        ws_req.we      = 1'b0;
        ws_req.waddr   = r_wr_idx;
        ws_req.wdata   = f_modify(ws_rdata_a, r_op, r_col, r_mask, r_plane, r_word);
        ws_req.raddr_a = r_idx;
        ws_req.raddr_b = ROW_AW'({1'b0, r_idx} + (ROW_AW+1)'(SCAN_ROWS));

        ds_req.we    = 1'b0;
        ds_req.waddr = SCAN_AW'(r_wr_idx);
        ds_req.wdata = {(lower_ok ? ws_rdata_b : {ENTRY_W{1'b0}}), ws_rdata_a};
        ds_req.raddr = r_scan_row;

        case (r_state)
            S_CLEAR: begin
                ws_req.we    = 1'b1;
                ws_req.waddr = r_idx;
                ws_req.wdata = '0;
                ds_req.we    = idx_scan;
                ds_req.waddr = SCAN_AW'(r_idx);
                ds_req.wdata = '0;
                if (r_idx == ROW_AW'(PANEL_ROWS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                ws_req.raddr_a = ROW_AW'(i_item.row);
                if (accept) begin
                    n_op    = i_item.operation;
                    n_col   = COL_W'(i_item.column);
                    n_mask  = i_item.color_mask;
                    n_plane = i_item.plane;
                    n_word  = i_item.row_word[C-1:0];
                    n_wr_idx = ROW_AW'(i_item.row);
                    case (i_item.operation)
                        OP_TICK: begin
                            if (frame_start) begin
                                n_state   = S_COPY;
                                n_idx     = '0;
                                n_rd_on   = 1'b1;
                                n_wr_pend = 1'b0;
                            end else begin
                                do_tick = 1'b1;
                            end
                        end
                        OP_CLR_PIXEL, OP_SET_PIXEL: begin
                            if (row_ok && col_ok) n_state = S_RMW;
                        end
                        OP_ROW_MASK: begin
                            if (row_ok) n_state = S_RMW;
                        end
                        OP_ROW_RAW: begin
                            if (row_ok && (i_item.plane != 2'd3)) n_state = S_RMW;
                        end
                        OP_FILL: begin
                            n_state   = S_FILL;
                            n_idx     = '0;
                            n_rd_on   = 1'b1;
                            n_wr_pend = 1'b0;
                        end
                        OP_CLEAR: begin
                            n_state = S_CLEAR;
                            n_idx   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_RMW: begin
                ws_req.we = 1'b1;
                n_state   = S_IDLE;
            end
            S_FILL: begin
                ws_req.we = r_wr_pend;
                n_wr_pend = r_rd_on;
                n_wr_idx  = r_idx;
                if (r_rd_on) begin
                    if (r_idx == ROW_AW'(PANEL_ROWS - 1)) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (r_wr_pend) begin
                    n_state = S_IDLE;
                end
            end
            S_COPY: begin
                ds_req.we = r_wr_pend;
                n_wr_pend = r_rd_on;
                n_wr_idx  = r_idx;
                if (r_rd_on) begin
                    if (r_idx == ROW_AW'(SCAN_ROWS - 1)) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (r_wr_pend) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                do_tick = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance the scan position for one tick
    assign dwell_next  = r_dwell_count + 16'd1;
    assign dwell_limit = (r_dwell_ticks == '0) ? 16'd1 : r_dwell_ticks;

    always_comb begin
        n_scan_row    = r_scan_row;
        n_scan_col    = r_scan_col;
        n_in_dwell    = r_in_dwell;
        n_dwell_count = r_dwell_count;
        n_out_pend    = do_tick;
        n_out_row     = r_out_row;
        n_out_shift   = r_out_shift;
        n_out_col     = r_out_col;
        if (do_tick) begin
            n_out_row = 5'(r_scan_row);
            n_out_col = r_scan_col;
            if (!r_in_dwell) begin
                n_out_shift = 1'b1;
                if (r_scan_col == '0) begin
                    n_scan_col    = COL_W'(PANEL_COLUMNS - 1);
                    n_in_dwell    = 1'b1;
                    n_dwell_count = '0;
                end else begin
                    n_scan_col = r_scan_col - 1'b1;
                end
            end else begin
                n_out_shift = 1'b0;
                if ((dwell_next >= dwell_limit) || (dwell_next == '0)) begin
                    n_in_dwell    = 1'b0;
                    n_dwell_count = '0;
                    if (r_scan_row == SCAN_AW'(SCAN_ROWS - 1)) begin
                        n_scan_row = '0;
                    end else begin
                        n_scan_row = r_scan_row + 1'b1;
                    end
                end else begin
                    n_dwell_count = dwell_next;
                end
            end
        end
    end

    // Hold control and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_idx         <= '0;
            r_rd_on       <= 1'b0;
            r_wr_pend     <= 1'b0;
            r_scan_row    <= '0;
            r_scan_col    <= COL_W'(PANEL_COLUMNS - 1);
            r_in_dwell    <= 1'b0;
            r_dwell_count <= '0;
            r_dwell_ticks <= DWELL_RESET;
            r_out_pend    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_rd_on       <= n_rd_on;
            r_wr_pend     <= n_wr_pend;
            r_scan_row    <= n_scan_row;
            r_scan_col    <= n_scan_col;
            r_in_dwell    <= n_in_dwell;
            r_dwell_count <= n_dwell_count;
            r_out_pend    <= n_out_pend;
            if (i_cfg_we) begin
                r_dwell_ticks <= i_cfg_wdata;
            end
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_wr_idx    <= n_wr_idx;
        r_op        <= n_op;
        r_col       <= n_col;
        r_mask      <= n_mask;
        r_plane     <= n_plane;
        r_word      <= n_word;
        r_out_row   <= n_out_row;
        r_out_shift <= n_out_shift;
        r_out_col   <= n_out_col;
    end

    // Drive the result beat from the display store read data
    always_comb begin
        logic [C-1:0] up_bits;
        logic [C-1:0] lo_bits;
        o_result.row_address = r_out_row;
        o_result.shift_pulse = r_out_shift;
        o_result.latch       = !r_out_shift;
        o_result.display_on  = !r_out_shift;
        for (int s = 0; s < 3; s++) begin
            up_bits = ds_rdata[s*C +: C];
            lo_bits = ds_rdata[ENTRY_W + s*C +: C];
            o_result.upper_rgb[s] = r_out_shift && up_bits[r_out_col];
            o_result.lower_rgb[s] = r_out_shift && lo_bits[r_out_col];
        end
    end

    assign o_strobe = r_out_pend;

endmodule

`default_nettype wire
